### rtl/swdh_pkg.sv
`default_nettype none

package swdh_pkg;

  localparam int unsigned DATA_W = 32;

  // request codes carried in req_type
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_XFER   = 2'd1;
  localparam logic [1:0] REQ_LRESET = 2'd2;

  // configuration register indexes
  localparam logic CFG_WAIT_RETRY = 1'b0;
  localparam logic CFG_TRAIL_IDLE = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] WAIT_RETRY_RST = 8'd10;
  localparam logic [7:0] TRAIL_IDLE_RST = 8'd8;

  // ack codes as sampled, lsb first
  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  // dp select register address and line reset constants
  localparam logic [7:0]        SELECT_ADDR  = 8'h08;
  localparam logic [7:0]        BANK_MASK    = 8'hF0;
  localparam logic [DATA_W-1:0] SELECT_INVAL = 32'hFFFF_FFFF;
  localparam logic [15:0]       JTAG_TO_SWD  = 16'hE79E;
  localparam logic [7:0]        HDR_BITS     = 8'd8;
  localparam logic [7:0]        ACK_BITS     = 8'd3;
  localparam logic [7:0]        LINE_BITS    = 8'd64;
  localparam logic [7:0]        SEQ_BITS     = 8'd16;
  localparam logic [7:0]        DATA_BITS    = 8'(DATA_W);

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_HDR  = 4'd1,
    PH_TRNR = 4'd2,
    PH_ACK  = 4'd3,
    PH_TRNW = 4'd4,
    PH_WDAT = 4'd5,
    PH_WPAR = 4'd6,
    PH_RDAT = 4'd7,
    PH_RPAR = 4'd8,
    PH_TAIL = 4'd9,
    PH_RTRN = 4'd10,
    PH_RON1 = 4'd11,
    PH_RJTS = 4'd12,
    PH_RON2 = 4'd13,
    PH_RZER = 4'd14
  } phase_e;

  // transfer outcome; retry is internal and never reported
  typedef enum logic [2:0] {
    OUT_OK       = 3'd0,
    OUT_FAULT    = 3'd1,
    OUT_TIMEOUT  = 3'd2,
    OUT_PROTOCOL = 3'd3,
    OUT_PARITY   = 3'd4,
    OUT_RETRY    = 3'd5
  } outcome_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              port_is_ap;
    logic              read_not_write;
    logic [7:0]        reg_addr;
    logic [7:0]        ap_index;
    logic [DATA_W-1:0] write_data;
    logic              swdio_in;
  } in_item_t;

  typedef struct packed {
    logic              swdio_out;
    logic              swdio_drive;
    logic              clock_pulse;
    logic              busy_res;
    logic              done_res;
    logic [2:0]        status;
    logic [DATA_W-1:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic [7:0] wait_retry_limit;
    logic [7:0] trailing_idle_bits;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/swd_host_transfer_engine.sv
// SWD host transfer engine, one SWCLK bit period per transfer.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): each transfer is one
// tick with the sampled SWDIO level; on an idle tick it may also start a
// DP/AP register access (with an automatic SELECT write when the AP index
// or bank changes) or a line reset sequence.
// Output channel (out_valid_o / out_stall_i / out_item_o): exactly one result
// per tick: the SWDIO level and drive enable, the clock pulse flag, busy,
// done, status and read data.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 wait retry limit, 1 trailing idle bits) on the same clock edge.
// A transfer's result is registered and offered in the next cycle; throughput
// is one tick per cycle while the receiver does not stall, set by the single
// pass of the bit sequencer between the input port and the result register.
// Reset clears the sequencer to idle, invalidates the SELECT cache and
// restores the config defaults (10 retries, 8 idle bits).
// While the receiver stalls, the result register holds and in_stall_o is
// raised, so no tick is taken until the pending result is transferred.
`default_nettype none

module swd_host_transfer_engine import swdh_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  cfg_t      cfg_q;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      in_fire;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_retry_limit   <= WAIT_RETRY_RST;
      cfg_q.trailing_idle_bits <= TRAIL_IDLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAIT_RETRY: cfg_q.wait_retry_limit   <= cfg_data_i;
        CFG_TRAIL_IDLE: cfg_q.trailing_idle_bits <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // take a tick whenever the result register is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  swdh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register
  always_comb begin
    if (in_fire) out_valid_d = 1'b1;
    else         out_valid_d = out_valid_q && out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted tick produced no result");

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> out_item_o.busy_res)
    else $error("done reported outside an operation");

  a_status_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.done_res |->
      (out_item_o.status == 3'd0 && out_item_o.read_data == '0))
    else $error("status or read data without done");

endmodule

`default_nettype wire

### rtl/swdh_core.sv
`default_nettype none

module swdh_core import swdh_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  input  wire cfg_t      cfg_i,
  output out_item_t      res_o
);

  // packet header: start, apndp, rnw, a2, a3, parity, stop, park
  function automatic logic [DATA_W-1:0] make_header(input logic sel, input logic ap,
                                                     input logic rnw, input logic [7:0] addr);
    logic c_ap;
    logic c_rnw;
    logic [7:0] c_addr;
    logic par;
    c_ap   = sel ? 1'b0 : ap;
    c_rnw  = sel ? 1'b0 : rnw;
    c_addr = sel ? SELECT_ADDR : addr;
    par    = c_ap ^ c_rnw ^ c_addr[2] ^ c_addr[3];
    return {{(DATA_W-8){1'b0}}, 1'b1, 1'b0, par, c_addr[3:2], c_rnw, c_ap, 1'b1};
  endfunction

  phase_e            phase_q, phase_d;
  logic [7:0]        cnt_q, cnt_d;
  logic [DATA_W-1:0] sr_q, sr_d;
  logic              par_q, par_d;
  logic [2:0]        ack_q, ack_d;
  logic [7:0]        retries_q, retries_d;
  outcome_e          outcome_q, outcome_d;
  logic [DATA_W-1:0] sel_cache_q, sel_cache_d;
  logic              sel_needed_q, sel_needed_d;

  // latched request, no reset: always written before use
  logic              rq_ap_q, rq_ap_d;
  logic              rq_rnw_q, rq_rnw_d;
  logic [7:0]        rq_addr_q, rq_addr_d;
  logic [7:0]        rq_apidx_q, rq_apidx_d;
  logic [DATA_W-1:0] rq_data_q, rq_data_d;

  // next state and result for one tick
  always_comb begin
    logic              conclude;
    logic [7:0]        cnt_inc;
    logic [DATA_W-1:0] sel_val;
    logic              c_rnw;

    phase_d      = phase_q;
    cnt_d        = cnt_q;
    sr_d         = sr_q;
    par_d        = par_q;
    ack_d        = ack_q;
    retries_d    = retries_q;
    outcome_d    = outcome_q;
    sel_cache_d  = sel_cache_q;
    sel_needed_d = sel_needed_q;
    rq_ap_d      = rq_ap_q;
    rq_rnw_d     = rq_rnw_q;
    rq_addr_d    = rq_addr_q;
    rq_apidx_d   = rq_apidx_q;
    rq_data_d    = rq_data_q;
    conclude     = 1'b0;
    cnt_inc      = cnt_q + 8'd1;

    res_o             = '0;
    res_o.swdio_drive = 1'b1;

    // start of a new operation when idle
    if (phase_q == PH_IDLE) begin
      if (item_i.req_type == REQ_XFER) begin
        rq_ap_d      = item_i.port_is_ap;
        rq_rnw_d     = item_i.read_not_write;
        rq_addr_d    = item_i.reg_addr;
        rq_apidx_d   = item_i.ap_index;
        rq_data_d    = item_i.write_data;
        sel_val      = {item_i.ap_index, 16'h0000, item_i.reg_addr & BANK_MASK};
        sel_needed_d = item_i.port_is_ap && (sel_val != sel_cache_q);
        retries_d    = cfg_i.wait_retry_limit;
        outcome_d    = OUT_OK;
        sr_d         = make_header(sel_needed_d, rq_ap_d, rq_rnw_d, rq_addr_d);
        phase_d      = PH_HDR;
        cnt_d        = '0;
        cnt_inc      = 8'd1;
      end else if (item_i.req_type == REQ_LRESET) begin
        sel_cache_d  = SELECT_INVAL;
        sel_needed_d = 1'b0;
        phase_d      = PH_RTRN;
        cnt_d        = '0;
        cnt_inc      = 8'd1;
      end
    end

    res_o.busy_res = (phase_d != PH_IDLE);
    sel_val = {rq_apidx_d, 16'h0000, rq_addr_d & BANK_MASK};
    c_rnw   = sel_needed_d ? 1'b0 : rq_rnw_d;

    // one bit period of the running phase
    if (phase_d != PH_IDLE) begin
      res_o.clock_pulse = 1'b1;
      unique case (phase_d)
        PH_HDR: begin
          res_o.swdio_out = sr_d[0];
          sr_d  = sr_d >> 1;
          cnt_d = cnt_inc;
          if (cnt_inc == HDR_BITS) begin
            phase_d = PH_TRNR;
            cnt_d   = '0;
          end
        end
        PH_TRNR: begin
          res_o.swdio_drive = 1'b0;
          phase_d = PH_ACK;
          cnt_d   = '0;
          ack_d   = '0;
        end
        PH_ACK: begin
          res_o.swdio_drive = 1'b0;
          ack_d = ack_q | (3'(item_i.swdio_in) << cnt_q[1:0]);
          cnt_d = cnt_inc;
          if (cnt_inc == ACK_BITS) begin
            cnt_d   = '0;
            phase_d = PH_TRNW;
            priority if (ack_d == ACK_OK) begin
              outcome_d = OUT_OK;
              if (c_rnw) begin
                phase_d = PH_RDAT;
                sr_d    = '0;
                par_d   = 1'b0;
              end
            end else if (ack_d == ACK_WAIT) begin
              if (retries_q == 8'd0) begin
                outcome_d = OUT_TIMEOUT;
              end else begin
                retries_d = retries_q - 8'd1;
                outcome_d = OUT_RETRY;
              end
            end else if (ack_d == ACK_FAULT) begin
              outcome_d = OUT_FAULT;
            end else begin
              outcome_d = OUT_PROTOCOL;
            end
          end
        end
        PH_TRNW: begin
          res_o.swdio_drive = 1'b0;
          if (outcome_q == OUT_OK && !c_rnw) begin
            phase_d = PH_WDAT;
            sr_d    = sel_needed_d ? sel_val : rq_data_d;
            par_d   = 1'b0;
            cnt_d   = '0;
          end else begin
            cnt_d = '0;
            if (cfg_i.trailing_idle_bits == 8'd0) conclude = 1'b1;
            else phase_d = PH_TAIL;
          end
        end
        PH_WDAT: begin
          res_o.swdio_out = sr_q[0];
          par_d = par_q ^ sr_q[0];
          sr_d  = sr_q >> 1;
          cnt_d = cnt_inc;
          if (cnt_inc == DATA_BITS) begin
            phase_d = PH_WPAR;
            cnt_d   = '0;
          end
        end
        PH_WPAR: begin
          res_o.swdio_out = par_q;
          cnt_d = '0;
          if (cfg_i.trailing_idle_bits == 8'd0) conclude = 1'b1;
          else phase_d = PH_TAIL;
        end
        PH_RDAT: begin
          res_o.swdio_drive = 1'b0;
          sr_d  = {item_i.swdio_in, sr_q[DATA_W-1:1]};
          par_d = par_q ^ item_i.swdio_in;
          cnt_d = cnt_inc;
          if (cnt_inc == DATA_BITS) begin
            phase_d = PH_RPAR;
            cnt_d   = '0;
          end
        end
        PH_RPAR: begin
          res_o.swdio_drive = 1'b0;
          outcome_d = (item_i.swdio_in == par_q) ? OUT_OK : OUT_PARITY;
          phase_d   = PH_TRNW;
        end
        PH_TAIL: begin
          res_o.swdio_out = 1'b0;
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.trailing_idle_bits) conclude = 1'b1;
        end
        PH_RTRN: begin
          res_o.swdio_drive = 1'b0;
          phase_d = PH_RON1;
          cnt_d   = '0;
        end
        PH_RON1: begin
          res_o.swdio_out = 1'b1;
          cnt_d = cnt_inc;
          if (cnt_inc == LINE_BITS) begin
            phase_d = PH_RJTS;
            cnt_d   = '0;
            sr_d    = {{(DATA_W-16){1'b0}}, JTAG_TO_SWD};
          end
        end
        PH_RJTS: begin
          res_o.swdio_out = sr_q[0];
          sr_d  = sr_q >> 1;
          cnt_d = cnt_inc;
          if (cnt_inc == SEQ_BITS) begin
            phase_d = PH_RON2;
            cnt_d   = '0;
          end
        end
        PH_RON2: begin
          res_o.swdio_out = 1'b1;
          cnt_d = cnt_inc;
          if (cnt_inc == LINE_BITS) begin
            phase_d = PH_RZER;
            cnt_d   = '0;
          end
        end
        PH_RZER: begin
          res_o.swdio_out = 1'b0;
          cnt_d = cnt_inc;
          if (cnt_inc == LINE_BITS) begin
            res_o.done_res = 1'b1;
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end
        end
        default: begin
          res_o.clock_pulse = 1'b0;
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end
      endcase
    end

    // end of an attempt: retry, follow a select write, or finish
    if (conclude) begin
      priority if (outcome_d == OUT_RETRY) begin
        sr_d    = make_header(sel_needed_d, rq_ap_d, rq_rnw_d, rq_addr_d);
        phase_d = PH_HDR;
        cnt_d   = '0;
      end else if (outcome_d == OUT_OK && sel_needed_d) begin
        sel_cache_d  = sel_val;
        sel_needed_d = 1'b0;
        retries_d    = cfg_i.wait_retry_limit;
        sr_d    = make_header(1'b0, rq_ap_d, rq_rnw_d, rq_addr_d);
        phase_d = PH_HDR;
        cnt_d   = '0;
      end else begin
        res_o.done_res  = 1'b1;
        res_o.status    = outcome_d;
        res_o.read_data = (outcome_d == OUT_OK && c_rnw) ? sr_d : '0;
        phase_d = PH_IDLE;
        cnt_d   = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cnt_q        <= '0;
      sr_q         <= '0;
      par_q        <= 1'b0;
      ack_q        <= '0;
      retries_q    <= '0;
      outcome_q    <= OUT_OK;
      sel_cache_q  <= SELECT_INVAL;
      sel_needed_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      sr_q         <= sr_d;
      par_q        <= par_d;
      ack_q        <= ack_d;
      retries_q    <= retries_d;
      outcome_q    <= outcome_d;
      sel_cache_q  <= sel_cache_d;
      sel_needed_q <= sel_needed_d;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      rq_ap_q    <= rq_ap_d;
      rq_rnw_q   <= rq_rnw_d;
      rq_addr_q  <= rq_addr_d;
      rq_apidx_q <= rq_apidx_d;
      rq_data_q  <= rq_data_d;
    end
  end

endmodule

`default_nettype wire
